// File: rtl/rau_pkg.sv
// rau_pkg: types and constants for the rational arithmetic unit
// used by rational_arithmetic_unit; no dependencies
package rau_pkg;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GCD_CHK,
    S_GCD_UPD,
    S_L1,
    S_L2,
    S_L3,
    S_L4,
    S_L5,
    S_L6,
    S_RED,
    S_SPLIT,
    S_F1,
    S_F2,
    S_F3,
    S_DIV,
    S_MUL,
    S_OUT
  } state_t;

endpackage

// File: rtl/rational_arithmetic_unit.sv
// rational_arithmetic_unit: two-fraction add, subtract, multiply, divide with gcd reduction
// depends on rau_pkg; one shared bit-serial divider and one registered 32x32 multiplier
// sequence: an infinite result goes from accept straight to the output step; otherwise the
//   run is set by the bit-serial divides, the euclid steps (gcd, lcm, whole part,
//   reduction) and the multiplies
// throughput: one item at a time; s_tready is high only while the sequencer is idle
// reset: rst clears the sequencer and the output valid; payload registers are not reset
module rational_arithmetic_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero fill
  input  logic [127:0] s_tdata,
  // action[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // negative[0], infinite[1], whole_part[64:2], frac_num[127:65], frac_den[190:128], zero
  output logic [191:0] m_tdata
);

  rau_pkg::state_t state, state_next, ret;

  logic [1:0]  act;
  logic        an, bn, rneg;
  logic [31:0] am, bm;
  logic [30:0] ad, bd;
  logic [63:0] gx, gy, q1, lv, ta, nmag, dmag, remv;
  logic [63:0] div_n, div_d, dr;
  logic [5:0]  cnt;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        res_neg, res_inf;
  logic [62:0] res_whole, res_fn, res_fd;

  logic [31:0] in_an, in_bn;
  logic [30:0] in_ad, in_bd;
  logic [64:0] trial;
  logic        take;
  logic        tbn;

  assign in_an = s_tdata[31:0];
  assign in_ad = s_tdata[62:32];
  assign in_bn = s_tdata[94:63];
  assign in_bd = s_tdata[125:95];

  assign s_tready = (state == rau_pkg::S_IDLE);
  assign trial = {dr, div_n[63]};
  assign take = (trial >= {1'b0, div_d});
  assign tbn = (act == rau_pkg::ACT_SUB) ? !bn : bn;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::S_IDLE: begin
        if (s_tvalid) begin
          if (in_ad == '0 || in_bd == '0 || (s_tuser == rau_pkg::ACT_DIV && in_bn == '0)) begin
            state_next = rau_pkg::S_OUT;
          end else if (s_tuser == rau_pkg::ACT_MUL || s_tuser == rau_pkg::ACT_DIV) begin
            state_next = rau_pkg::S_MUL;
          end else begin
            state_next = rau_pkg::S_GCD_CHK;
          end
        end
      end
      rau_pkg::S_GCD_CHK: state_next = (gy == '0) ? ret : rau_pkg::S_DIV;
      rau_pkg::S_GCD_UPD: state_next = rau_pkg::S_GCD_CHK;
      rau_pkg::S_L1:      state_next = rau_pkg::S_DIV;
      rau_pkg::S_L2:      state_next = rau_pkg::S_MUL;
      rau_pkg::S_L3:      state_next = rau_pkg::S_DIV;
      rau_pkg::S_L4:      state_next = rau_pkg::S_MUL;
      rau_pkg::S_L5:      state_next = rau_pkg::S_MUL;
      rau_pkg::S_L6:      state_next = rau_pkg::S_RED;
      rau_pkg::S_RED:     state_next = (nmag == '0) ? rau_pkg::S_OUT : rau_pkg::S_DIV;
      rau_pkg::S_SPLIT:   state_next = (dr == '0) ? rau_pkg::S_OUT : rau_pkg::S_GCD_CHK;
      rau_pkg::S_F1:      state_next = rau_pkg::S_DIV;
      rau_pkg::S_F2:      state_next = rau_pkg::S_DIV;
      rau_pkg::S_F3:      state_next = rau_pkg::S_OUT;
      rau_pkg::S_DIV:     state_next = (cnt == '0) ? ret : rau_pkg::S_DIV;
      rau_pkg::S_MUL:     state_next = ret;
      rau_pkg::S_OUT:     state_next = (!m_tvalid || m_tready) ? rau_pkg::S_IDLE : rau_pkg::S_OUT;
      default:            state_next = rau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
    case (state)
      rau_pkg::S_IDLE: begin
        act <= s_tuser;
        an <= in_an[31];
        bn <= in_bn[31];
        am <= in_an[31] ? (~in_an + 32'd1) : in_an;
        bm <= in_bn[31] ? (~in_bn + 32'd1) : in_bn;
        ad <= in_ad;
        bd <= in_bd;
        gx <= {33'd0, in_ad};
        gy <= {33'd0, in_bd};
        res_neg <= 1'b0;
        res_inf <= (in_ad == '0 || in_bd == '0 || (s_tuser == rau_pkg::ACT_DIV && in_bn == '0));
        res_whole <= '0;
        res_fn <= '0;
        res_fd <= '0;
        rneg <= in_an[31] != in_bn[31];
        if (s_tuser == rau_pkg::ACT_MUL) begin
          mul_a <= in_an[31] ? (~in_an + 32'd1) : in_an;
          mul_b <= in_bn[31] ? (~in_bn + 32'd1) : in_bn;
          ret <= rau_pkg::S_L5;
        end else begin
          mul_a <= in_an[31] ? (~in_an + 32'd1) : in_an;
          mul_b <= {1'b0, in_bd};
          ret <= (s_tuser == rau_pkg::ACT_DIV) ? rau_pkg::S_L5 : rau_pkg::S_L1;
        end
      end
      rau_pkg::S_GCD_CHK: begin
        div_n <= gx;
        div_d <= gy;
        dr <= '0;
        cnt <= 6'd63;
        if (gy != '0) begin
          ret <= rau_pkg::S_GCD_UPD;
        end
      end
      rau_pkg::S_GCD_UPD: begin
        gx <= gy;
        gy <= dr;
        ret <= (act == rau_pkg::ACT_ADD || act == rau_pkg::ACT_SUB) && lv == '0 ?
               rau_pkg::S_L1 : rau_pkg::S_F1;
      end
      rau_pkg::S_L1: begin
        // gcd of the denominators sits in gx
        div_n <= {33'd0, ad};
        div_d <= gx;
        dr <= '0;
        cnt <= 6'd63;
        ret <= rau_pkg::S_L2;
      end
      rau_pkg::S_L2: begin
        q1 <= div_n;
        mul_a <= div_n[31:0];
        mul_b <= {1'b0, bd};
        ret <= rau_pkg::S_L3;
      end
      rau_pkg::S_L3: begin
        lv <= prod;
        div_n <= {33'd0, bd};
        div_d <= gx;
        dr <= '0;
        cnt <= 6'd63;
        ret <= rau_pkg::S_L4;
      end
      rau_pkg::S_L4: begin
        mul_a <= am;
        mul_b <= div_n[31:0];
        ret <= rau_pkg::S_L5;
      end
      rau_pkg::S_L5: begin
        if (act == rau_pkg::ACT_MUL || act == rau_pkg::ACT_DIV) begin
          nmag <= prod;
          mul_a <= {1'b0, ad};
          mul_b <= (act == rau_pkg::ACT_MUL) ? {1'b0, bd} : bm;
        end else begin
          ta <= prod;
          mul_a <= bm;
          mul_b <= q1[31:0];
        end
        ret <= rau_pkg::S_L6;
      end
      rau_pkg::S_L6: begin
        if (act == rau_pkg::ACT_MUL || act == rau_pkg::ACT_DIV) begin
          dmag <= prod;
        end else begin
          dmag <= lv;
          if (an == tbn) begin
            nmag <= ta + prod;
            rneg <= an;
          end else if (ta >= prod) begin
            nmag <= ta - prod;
            rneg <= an;
          end else begin
            nmag <= prod - ta;
            rneg <= tbn;
          end
        end
      end
      rau_pkg::S_RED: begin
        div_n <= nmag;
        div_d <= dmag;
        dr <= '0;
        cnt <= 6'd63;
        ret <= rau_pkg::S_SPLIT;
        // marks the final gcd pass for the return decode
        lv <= 64'd1;
      end
      rau_pkg::S_SPLIT: begin
        res_whole <= div_n[62:0];
        res_neg <= rneg;
        remv <= dr;
        gx <= dr;
        gy <= dmag;
        ret <= rau_pkg::S_F1;
      end
      rau_pkg::S_F1: begin
        div_n <= remv;
        div_d <= gx;
        dr <= '0;
        cnt <= 6'd63;
        ret <= rau_pkg::S_F2;
      end
      rau_pkg::S_F2: begin
        res_fn <= div_n[62:0];
        div_n <= dmag;
        div_d <= gx;
        dr <= '0;
        cnt <= 6'd63;
        ret <= rau_pkg::S_F3;
      end
      rau_pkg::S_F3: begin
        res_fd <= div_n[62:0];
      end
      rau_pkg::S_DIV: begin
        // restoring divide, one quotient bit a cycle
        dr <= take ? (trial[63:0] - div_d) : trial[63:0];
        div_n <= {div_n[62:0], take};
        cnt <= cnt - 6'd1;
      end
      default: begin
      end
    endcase
    if (state == rau_pkg::S_IDLE) begin
      lv <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == rau_pkg::S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rau_pkg::S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, res_fd, res_fn, res_whole, res_inf, res_neg};
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == rau_pkg::S_DIV |-> div_d != '0)
    else $error("divider started with zero divisor");

  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == rau_pkg::S_OUT)
    else $error("result shown outside the output step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sequencer did not leave idle after an accepted item");

  a_inf_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0] == 1'b0 && m_tdata[64:2] == '0)
    else $error("infinite result carries a value");

endmodule
